>>> hw/rtl/dle_sd_pkg.sv
`default_nettype none

package dle_sd_pkg;

    // Control characters of the shielding scheme.
    localparam logic [7:0] DLE_CODE = 8'h10;
    localparam logic [7:0] SUB_CODE = 8'h1A;
    localparam logic [7:0] EXT_CODE = 8'h58;
    localparam logic [7:0] END_CODE = 8'h2E;
    localparam logic [7:0] CR_CODE  = 8'h0D;
    localparam logic [7:0] LF_CODE  = 8'h0A;

    // The notice text CR LF "+DLE: ".
    localparam int HEAD_LEN = 8;
    localparam logic [7:0] NOTICE_HEAD [HEAD_LEN] = '{
        8'h0D, 8'h0A, 8'h2B, 8'h44, 8'h4C, 8'h45, 8'h3A, 8'h20
    };

    // Parser state held by the front end.
    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_PENDING,
        MODE_EXT,
        MODE_EXT_DLE
    } parse_mode_t;

    // Kinds of output run that the front end asks the back end to emit.
    typedef enum logic [2:0] {
        CMD_BYTE,
        CMD_PAIR,
        CMD_HEAD,
        CMD_NOTICE,
        CMD_CRLF
    } cmd_kind_t;

    // Position within a run; the longest run has eleven words.
    typedef logic [3:0] run_idx_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    // Position of the final word of a run.
    function automatic run_idx_t run_last(input cmd_kind_t kind);
        run_idx_t r;
        case (kind)
            CMD_BYTE:   r = 4'd0;
            CMD_PAIR:   r = 4'd1;
            CMD_HEAD:   r = 4'd7;
            CMD_NOTICE: r = 4'd10;
            CMD_CRLF:   r = 4'd1;
            default:    r = 4'd0;
        endcase
        return r;
    endfunction

    // Word emitted at a given position of a run.
    function automatic logic [7:0] run_byte(input cmd_t cmd, input run_idx_t idx);
        logic [7:0] r;
        case (cmd.kind)
            CMD_BYTE:   r = cmd.data;
            CMD_PAIR:   r = (idx == 4'd0) ? DLE_CODE : cmd.data;
            CMD_HEAD:   r = NOTICE_HEAD[idx[2:0]];
            CMD_NOTICE:
            begin
                if (idx < 4'd8)
                    r = NOTICE_HEAD[idx[2:0]];
                else if (idx == 4'd8)
                    r = cmd.data;
                else if (idx == 4'd9)
                    r = CR_CODE;
                else
                    r = LF_CODE;
            end
            CMD_CRLF:   r = (idx == 4'd0) ? CR_CODE : LF_CODE;
            default:    r = cmd.data;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dle_rx_if.sv
`default_nettype none

// Channel carrying raw received bytes.
interface dle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dle_out_if.sv
`default_nettype none

// Channel carrying decoded bytes for the command channel.
interface dle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dle_sd_front.sv
`default_nettype none

module dle_sd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    dle_rx_if.sink             rx,
    output dle_sd_pkg::cmd_t   push_cmd,
    output logic               push_valid,
    input  wire logic          push_ready
);
    import dle_sd_pkg::*;

    parse_mode_t parse_mode_reg;
    parse_mode_t parse_mode_next;
    logic        accept;

    // A word is taken whenever the queue has room, whatever it produces.
    assign rx.ready = push_ready;
    assign accept   = rx.valid && push_ready;

    // Classify the incoming word into a run command and the next mode.
    always_comb
    begin
        parse_mode_next = parse_mode_reg;
        push_valid      = 1'b0;
        push_cmd.kind   = CMD_BYTE;
        push_cmd.data   = rx.rx_byte;
        if (accept)
        begin
            case (parse_mode_reg)
                MODE_NORMAL:
                begin
                    if (rx.rx_byte == DLE_CODE)
                        parse_mode_next = MODE_PENDING;
                    else
                        push_valid = 1'b1;
                end
                MODE_PENDING:
                begin
                    push_valid      = 1'b1;
                    parse_mode_next = MODE_NORMAL;
                    if (rx.rx_byte == DLE_CODE)
                    begin
                        push_cmd.kind = CMD_BYTE;
                    end
                    else if (rx.rx_byte == SUB_CODE)
                    begin
                        push_cmd.kind = CMD_PAIR;
                        push_cmd.data = DLE_CODE;
                    end
                    else if (rx.rx_byte == EXT_CODE)
                    begin
                        push_cmd.kind   = CMD_HEAD;
                        parse_mode_next = MODE_EXT;
                    end
                    else
                    begin
                        push_cmd.kind = CMD_NOTICE;
                    end
                end
                MODE_EXT:
                begin
                    if (rx.rx_byte == DLE_CODE)
                        parse_mode_next = MODE_EXT_DLE;
                    else
                        push_valid = 1'b1;
                end
                MODE_EXT_DLE:
                begin
                    push_valid = 1'b1;
                    if (rx.rx_byte == END_CODE)
                    begin
                        push_cmd.kind   = CMD_CRLF;
                        parse_mode_next = MODE_NORMAL;
                    end
                    else if (rx.rx_byte == DLE_CODE)
                    begin
                        push_cmd.kind = CMD_BYTE;
                    end
                    else
                    begin
                        push_cmd.kind   = CMD_PAIR;
                        parse_mode_next = MODE_EXT;
                    end
                end
                default:
                begin
                    parse_mode_next = MODE_NORMAL;
                end
            endcase
        end
    end

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            parse_mode_reg <= MODE_NORMAL;
        else
            parse_mode_reg <= parse_mode_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/dle_sd_queue.sv
`default_nettype none

module dle_sd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dle_sd_pkg::cmd_t push_cmd,
    input  wire logic             push_valid,
    output logic                  push_ready,
    output dle_sd_pkg::cmd_t      pop_cmd,
    output logic                  pop_valid,
    input  wire logic             pop_ready
);
    import dle_sd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

>>> hw/rtl/dle_sd_back.sv
`default_nettype none

module dle_sd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dle_sd_pkg::cmd_t pop_cmd,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    dle_out_if.source             tx
);
    import dle_sd_pkg::*;

    cmd_t     cmd_reg;
    cmd_t     cmd_next;
    run_idx_t idx_reg;
    run_idx_t idx_next;
    logic     busy_reg;
    logic     busy_next;
    logic     at_last;
    logic     fire;
    logic     load;

    assign at_last = (idx_reg == run_last(cmd_reg.kind));
    assign fire    = busy_reg && tx.ready;
    assign load    = !busy_reg || (fire && at_last);

    assign pop_ready      = load;
    assign tx.valid       = busy_reg;
    assign tx.out_byte    = run_byte(cmd_reg, idx_reg);
    assign tx.last_of_run = at_last;

    // Step through the run; take the next command as the last word leaves.
    always_comb
    begin
        busy_next = busy_reg;
        cmd_next  = cmd_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = pop_valid;
            idx_next  = '0;
            if (pop_valid)
                cmd_next = pop_cmd;
        end
        else if (fire)
        begin
            idx_next = idx_reg + run_idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Current command; payload needs no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/dle_shielded_stream_decoder.sv
// A received word that produces output passes the queue slot and the run sequencer's command
// register before its first result word shows. Throughput: one result word per cycle while
// the receiver is ready, one run of one to eleven words at a time. Input words that produce
// nothing are taken one per cycle while the command queue has room.
// Reset: rst_n is asynchronous and active low; it clears the parser mode, the queue and the run
// sequencer, so the block starts in normal mode with no DLE pending and nothing to emit.
`default_nettype none

module dle_shielded_stream_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dle_rx_if.sink    rx,
    dle_out_if.source tx
);
    import dle_sd_pkg::*;

    cmd_t push_cmd;
    logic push_valid;
    logic push_ready;
    cmd_t pop_cmd;
    logic pop_valid;
    logic pop_ready;

    // Front end: parses received words into run commands.
    dle_sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // Command queue between the two halves.
    dle_sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // Back end: emits each run one word per cycle while the receiver is ready.
    dle_sd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_cmd   (pop_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .tx        (tx)
    );

endmodule

`default_nettype wire

>>> hw/rtl/dle_sd_checker.sv
`default_nettype none

module dle_sd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] in_byte,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_last
);

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled result word changed");

    // A run continues without a gap once a word that is not its last has gone.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("run broken after a non-final word");

    // With nothing on the output, the input side is never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while the output is idle");

    // An input word that sits unaccepted keeps its value while it stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> $stable(in_byte) || !in_valid)
        else $error("input word observed changing while stalled");

endmodule

bind dle_shielded_stream_decoder dle_sd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .in_byte   (rx.rx_byte),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .out_byte  (tx.out_byte),
    .out_last  (tx.last_of_run)
);

`default_nettype wire

>>> test/dle_decode_monitor.sv
// Watches both channels of the DLE decoder, works out the decoded words that each received
// word should produce and compares them, in order, with the words that leave the block.
module dle_decode_monitor
    import dle_sd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dle_rx_if    rx,
    dle_out_if   tx,
    output int   mismatch_count,
    output int   words_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } decoded_word_t;

    // Decoded words still to come out of the block, oldest first.
    decoded_word_t decoded_words[$];
    parse_mode_t   shield_mode;

    function automatic void push_decoded(input logic [7:0] b);
        decoded_word_t w;
        w.data = b;
        w.last = 1'b0;
        decoded_words.push_back(w);
    endfunction

    function automatic void push_notice_head();
        for (int i = 0; i < HEAD_LEN; i++)
        begin
            push_decoded(NOTICE_HEAD[i]);
        end
    endfunction

    function automatic void push_crlf();
        push_decoded(CR_CODE);
        push_decoded(LF_CODE);
    endfunction

    // Advances the shielding state by one received word and queues what it produces.
    function automatic void unshield_word(input logic [7:0] b);
        int size_before;
        size_before = decoded_words.size();
        case (shield_mode)
            MODE_NORMAL:
            begin
                if (b == DLE_CODE)
                    shield_mode = MODE_PENDING;
                else
                    push_decoded(b);
            end
            MODE_PENDING:
            begin
                if (b == DLE_CODE)
                begin
                    push_decoded(DLE_CODE);
                    shield_mode = MODE_NORMAL;
                end
                else if (b == SUB_CODE)
                begin
                    push_decoded(DLE_CODE);
                    push_decoded(DLE_CODE);
                    shield_mode = MODE_NORMAL;
                end
                else if (b == EXT_CODE)
                begin
                    push_notice_head();
                    shield_mode = MODE_EXT;
                end
                else
                begin
                    push_notice_head();
                    push_decoded(b);
                    push_crlf();
                    shield_mode = MODE_NORMAL;
                end
            end
            MODE_EXT:
            begin
                if (b == DLE_CODE)
                    shield_mode = MODE_EXT_DLE;
                else
                    push_decoded(b);
            end
            default:
            begin
                if (b == END_CODE)
                begin
                    push_crlf();
                    shield_mode = MODE_NORMAL;
                end
                else if (b == DLE_CODE)
                begin
                    // The new DLE may still open the closing pair.
                    push_decoded(DLE_CODE);
                    shield_mode = MODE_EXT_DLE;
                end
                else
                begin
                    push_decoded(DLE_CODE);
                    push_decoded(b);
                    shield_mode = MODE_EXT;
                end
            end
        endcase
        // Only the final word of the run carries the end mark.
        if (decoded_words.size() > size_before)
            decoded_words[decoded_words.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decoded_word_t exp_word;
        if (!rst_n)
        begin
            decoded_words.delete();
            shield_mode    = MODE_NORMAL;
            mismatch_count = 0;
            words_owed     = 0;
        end
        else
        begin
            // A received word is taken before any output word of the same edge is matched.
            if (rx.valid && rx.ready)
                unshield_word(rx.rx_byte);

            if (tx.valid && tx.ready)
            begin
                if (decoded_words.size() == 0)
                begin
                    $error("unexpected word: out_byte %h, last_of_run %b",
                           tx.out_byte, tx.last_of_run);
                    mismatch_count++;
                end
                else
                begin
                    exp_word = decoded_words.pop_front();
                    if (tx.out_byte !== exp_word.data)
                    begin
                        $error("out_byte: expected %h, actual %h", exp_word.data, tx.out_byte);
                        mismatch_count++;
                    end
                    if (tx.last_of_run !== exp_word.last)
                    begin
                        $error("last_of_run: expected %b, actual %b",
                               exp_word.last, tx.last_of_run);
                        mismatch_count++;
                    end
                end
            end
            words_owed = decoded_words.size();
        end
    end

endmodule

>>> test/dle_shielded_stream_decoder_tb.sv
// Drives raw modem words into the DLE decoder and leaves the checking to the monitor.
module dle_shielded_stream_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dle_sd_pkg::*;

    logic clk;
    logic rst_n;
    int   send_idle;
    int   recv_idle;
    int   words_sent;
    int   mismatch_count;
    int   words_owed;

    dle_rx_if  rx_ch ();
    dle_out_if tx_ch ();

    dle_shielded_stream_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    dle_decode_monitor decode_mon (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx             (rx_ch),
        .tx             (tx_ch),
        .mismatch_count (mismatch_count),
        .words_owed     (words_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        tx_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Offers one word, idling first at random, and returns at the falling edge after it is taken.
    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    // Any word that is neither DLE nor the closing full stop.
    function automatic logic [7:0] message_word();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == DLE_CODE || b == END_CODE)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // Sends one randomly chosen sequence; most are well formed, the rest are noise.
    task automatic send_sequence();
        int         pick;
        int         len;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            b = 8'($urandom_range(255));
            while (b == DLE_CODE)
                b = 8'($urandom_range(255));
            send_word(b);
        end
        else if (pick < 40)
        begin
            send_word(DLE_CODE);
            send_word(DLE_CODE);
        end
        else if (pick < 48)
        begin
            send_word(DLE_CODE);
            send_word(SUB_CODE);
        end
        else if (pick < 60)
        begin
            send_word(DLE_CODE);
            send_word(8'($urandom_range(255)));
        end
        else if (pick < 85)
        begin
            // Extended message with shielded DLEs scattered through it.
            send_word(DLE_CODE);
            send_word(EXT_CODE);
            len = $urandom_range(6);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < 15)
                    send_word(DLE_CODE);
                if ($urandom_range(99) < 10)
                    send_word(DLE_CODE);
                send_word(message_word());
            end
            // Now and then the message is left open.
            if ($urandom_range(99) < 90)
            begin
                send_word(DLE_CODE);
                send_word(END_CODE);
            end
        end
        else
        begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < 25)
                    send_word(DLE_CODE);
                else
                    send_word(8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        tx_ch.ready   = 1'b0;
        words_sent    = 0;
        send_idle     = 16;
        recv_idle     = 60;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words: field extremes, the plain escapes and notices, then one message
        // holding shielded DLEs, a DLE run and the closing pair.
        send_word(8'h00);
        send_word(8'hFF);
        send_word(END_CODE);
        send_word(EXT_CODE);
        send_word(DLE_CODE);
        send_word(DLE_CODE);
        send_word(DLE_CODE);
        send_word(SUB_CODE);
        send_word(DLE_CODE);
        send_word(8'h00);
        send_word(DLE_CODE);
        send_word(8'hFF);
        send_word(DLE_CODE);
        send_word(END_CODE);
        send_word(DLE_CODE);
        send_word(EXT_CODE);
        send_word(8'h41);
        send_word(DLE_CODE);
        send_word(8'h41);
        send_word(DLE_CODE);
        send_word(SUB_CODE);
        send_word(DLE_CODE);
        send_word(DLE_CODE);
        send_word(DLE_CODE);
        send_word(END_CODE);

        // Hold off until the decoder has drained completely.
        rx_ch.valid <= 1'b0;
        wait (words_owed == 0);
        @(negedge clk);

        while (words_sent < 170)
            send_sequence();
        send_idle = 60;
        recv_idle = 16;
        while (words_sent < 320)
            send_sequence();
        send_idle = 0;
        recv_idle = 0;
        while (words_sent < 465)
            send_sequence();

        rx_ch.valid <= 1'b0;
        wait (words_owed == 0);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && words_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
